// File: rtl/core/kded_pkg.sv
// Shared constants, codes and types of the key debounce and event dispatcher.
package kded_pkg;

   localparam int KEY_COUNT  = 4;
   localparam int FIELD_KEYS = 4;
   localparam int LIVE_KEYS  = (KEY_COUNT < FIELD_KEYS) ? KEY_COUNT : FIELD_KEYS;

   localparam int OP_W        = 3;
   localparam int EVENT_W     = 3;
   localparam int HIST_W      = 8;
   localparam int CNT_W       = 8;
   localparam int TIME_W      = 32;
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 8;

   localparam logic [HIST_W-1:0]     PRESS_PATTERN = 8'h7f;
   localparam logic [FIELD_KEYS-1:0] ACTIVE_RESET  = 4'd8;
   localparam logic [CNT_W-1:0]      HOLD_RESET    = 8'd50;

   typedef enum logic [OP_W-1:0] {
      OP_SAMPLE  = 3'd0,
      OP_TICK    = 3'd1,
      OP_TIMEOUT = 3'd2,
      OP_UNLOCK  = 3'd3,
      OP_POLL    = 3'd4
   } op_type;

   localparam logic [EVENT_W-1:0] EV_NONE        = 3'd0;
   localparam logic [EVENT_W-1:0] EV_CASE_UNLOCK = 3'd5;
   localparam logic [EVENT_W-1:0] EV_TICK        = 3'd6;
   localparam logic [EVENT_W-1:0] EV_TIMEOUT     = 3'd7;

   localparam logic [CSR_INDEX_W-1:0] CSR_ACTIVE_LEVELS = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_HOLD_TICKS    = 4'd1;

   typedef struct packed {
      logic sample_en;
      logic key_bit;
      logic clear_en;
   } lane_ctl_type;

   typedef struct packed {
      logic pending;
      logic pressed_next;
   } lane_stat_type;

   typedef struct packed {
      logic   fire;
      op_type op;
      logic   was_locked;
      logic   time_reached;
   } arb_req_type;

endpackage

// File: rtl/core/kded_channels.sv
// Channel interfaces of the key debounce and event dispatcher.
interface kded_req_if import kded_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [OP_W-1:0]       operation;
   logic [FIELD_KEYS-1:0] first_levels;
   logic [FIELD_KEYS-1:0] second_levels;
   logic                  was_locked;
   logic [TIME_W-1:0]     now_time;
   logic [TIME_W-1:0]     unlock_time;

   modport source (output valid, operation, first_levels, second_levels, was_locked,
                   now_time, unlock_time, input ready);
   modport sink (input valid, operation, first_levels, second_levels, was_locked,
                 now_time, unlock_time, output ready);
endinterface

interface kded_rsp_if import kded_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [EVENT_W-1:0]    event_code;
   logic [FIELD_KEYS-1:0] debounced_levels;

   modport source (output valid, event_code, debounced_levels, input ready);
   modport sink (input valid, event_code, debounced_levels, output ready);
endinterface

interface kded_csr_if import kded_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  wdata;

   modport source (output valid, index, wdata, input ready);
   modport sink (input valid, index, wdata, output ready);
endinterface

// File: rtl/core/kded_key_lane.sv
// One key lane: sample history, debounced level and press-hold counter.
module kded_key_lane import kded_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  lane_ctl_type     ctl,
   input  logic [CNT_W-1:0] hold_ticks,
   output lane_stat_type    stat
);

   logic [HIST_W-1:0] hist_ff, hist_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              pressed_ff, pressed_in;
   logic [CNT_W-1:0]  cnt_loaded;

   always_comb begin
      hist_in    = hist_ff;
      cnt_in     = cnt_ff;
      pressed_in = pressed_ff;
      cnt_loaded = cnt_ff;
      if (ctl.sample_en) begin
         hist_in = {hist_ff[HIST_W-2:0], ctl.key_bit};
         if (hist_in == PRESS_PATTERN) begin
            pressed_in = 1'b1;
            cnt_loaded = hold_ticks;
         end else if (hist_in == '0) begin
            pressed_in = 1'b0;
         end
         // The counter runs down on every sample, including the one that loads it.
         cnt_in = (cnt_loaded != '0) ? cnt_loaded - 1'b1 : '0;
      end else if (ctl.clear_en) begin
         cnt_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_ff    <= '0;
         cnt_ff     <= '0;
         pressed_ff <= 1'b0;
      end else begin
         hist_ff    <= hist_in;
         cnt_ff     <= cnt_in;
         pressed_ff <= pressed_in;
      end
   end

   assign stat.pending      = (cnt_ff != '0);
   assign stat.pressed_next = pressed_in;

   a_press_sets_level: assert property (@(posedge clock) disable iff (reset)
      (ctl.sample_en && hist_in == PRESS_PATTERN) |=> pressed_ff)
      else $error("press pattern did not set the debounced level");

   a_clear_empties_counter: assert property (@(posedge clock) disable iff (reset)
      (ctl.clear_en && !ctl.sample_en) |=> (cnt_ff == '0))
      else $error("consumed press left its counter running");

endmodule

// File: rtl/core/kded_event_arb.sv
// Merge stage: pending flags and fixed-priority pick of the poll event.
module kded_event_arb import kded_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  arb_req_type          req,
   input  logic [LIVE_KEYS-1:0] pending,
   output logic [LIVE_KEYS-1:0] grant,
   output logic [EVENT_W-1:0]   event_code
);

   logic tick_ff, tick_in;
   logic timeout_ff, timeout_in;
   logic unlock_ff, unlock_in;
   logic poll_en;
   logic key_found;
   logic [EVENT_W-1:0] key_code;

   assign poll_en = req.fire && (req.op == OP_POLL);

   // Lowest-numbered lane with a live press counter wins.
   always_comb begin
      grant     = '0;
      key_found = 1'b0;
      key_code  = EV_NONE;
      for (int i = 0; i < LIVE_KEYS; i++) begin
         if (pending[i] && !key_found) begin
            grant[i]  = poll_en;
            key_found = 1'b1;
            key_code  = EVENT_W'(i + 1);
         end
      end
   end

   always_comb begin
      tick_in    = tick_ff;
      timeout_in = timeout_ff;
      unlock_in  = unlock_ff;
      event_code = EV_NONE;
      if (req.fire) begin
         case (req.op)
            OP_TICK:    tick_in    = 1'b1;
            OP_TIMEOUT: timeout_in = 1'b1;
            OP_UNLOCK:  unlock_in  = 1'b1;
            OP_POLL: begin
               if (key_found) begin
                  event_code = key_code;
               end else if (req.was_locked && req.time_reached) begin
                  event_code = EV_CASE_UNLOCK;
               end else if (req.was_locked && unlock_ff) begin
                  event_code = EV_CASE_UNLOCK;
                  unlock_in  = 1'b0;
               end else if (tick_ff) begin
                  event_code = EV_TICK;
                  tick_in    = 1'b0;
               end else if (timeout_ff) begin
                  event_code = EV_TIMEOUT;
                  timeout_in = 1'b0;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff    <= 1'b0;
         timeout_ff <= 1'b0;
         unlock_ff  <= 1'b0;
      end else begin
         tick_ff    <= tick_in;
         timeout_ff <= timeout_in;
         unlock_ff  <= unlock_in;
      end
   end

   a_grant_single: assert property (@(posedge clock) disable iff (reset)
      (poll_en && (pending != '0)) |-> $onehot(grant))
      else $error("poll with pending presses must consume exactly one");

   a_tick_held: assert property (@(posedge clock) disable iff (reset)
      (req.fire && req.op == OP_TICK) |=> tick_ff)
      else $error("tick word did not leave a pending tick");

   a_tick_consumed: assert property (@(posedge clock) disable iff (reset)
      (poll_en && event_code == EV_TICK) |=> !tick_ff)
      else $error("reported tick was not consumed");

endmodule

// File: rtl/core/key_debounce_event_dispatcher.sv
// Top level of the key debounce and event dispatcher.
// Usage:
//   req_ch carries one word per operation: key sample (two raw pin reads),
//   tick expired, generic timeout, force unlock or poll (lock state and times).
//   rsp_ch returns exactly one word per request: the event code (nonzero only
//   for a poll that finds something) and the debounced key levels after it.
//   csr_ch writes the per-key active levels (index 0) and the press-hold
//   count (index 1); it is always ready and should be used while idle.
// Timing:
//   Every request is handled in the cycle it is accepted; one key lane per
//   key updates its history and counter in parallel and the merge stage
//   picks the poll event in the same cycle. The response appears in the cycle
//   after acceptance, from an output register. Throughput is one word per
//   cycle while rsp_ch is not stalled, set by that single output register.
// Reset and stall:
//   Reset clears all histories, counters, levels and pending flags and
//   restores the register defaults (active levels 8, hold count 50).
//   While rsp_ch is stalled with a word held, req_ch.ready drops, so no
//   request is taken until the held word leaves.
module key_debounce_event_dispatcher import kded_pkg::*; (
   input logic         clock,
   input logic         reset,
   kded_req_if.sink    req_ch,
   kded_rsp_if.source  rsp_ch,
   kded_csr_if.sink    csr_ch
);

   logic [FIELD_KEYS-1:0] active_ff;
   logic [CNT_W-1:0]      hold_ff;
   logic                  rsp_valid_ff;
   logic [EVENT_W-1:0]    rsp_event_ff;
   logic [FIELD_KEYS-1:0] rsp_levels_ff;

   logic                  fire;
   op_type                op;
   arb_req_type           arb_req;
   lane_ctl_type          lane_ctl [LIVE_KEYS];
   lane_stat_type         lane_stat [LIVE_KEYS];
   logic [LIVE_KEYS-1:0]  pending;
   logic [LIVE_KEYS-1:0]  grant;
   logic [EVENT_W-1:0]    event_code;
   logic [FIELD_KEYS-1:0] levels_next;

   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign fire         = req_ch.valid && req_ch.ready;
   assign op           = op_type'(req_ch.operation);

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= ACTIVE_RESET;
         hold_ff   <= HOLD_RESET;
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            CSR_ACTIVE_LEVELS: active_ff <= csr_ch.wdata[FIELD_KEYS-1:0];
            CSR_HOLD_TICKS:    hold_ff   <= csr_ch.wdata[CNT_W-1:0];
            default: ;
         endcase
      end
   end

   genvar g;
   generate
      for (g = 0; g < FIELD_KEYS; g++) begin : g_key
         if (g < LIVE_KEYS) begin : g_live
            // A sample counts as pressed only when both reads match the active level.
            assign lane_ctl[g].sample_en = fire && (op == OP_SAMPLE);
            assign lane_ctl[g].key_bit   = (req_ch.first_levels[g] == active_ff[g]) &&
                                           (req_ch.second_levels[g] == active_ff[g]);
            assign lane_ctl[g].clear_en  = grant[g];

            kded_key_lane u_lane (
               .clock      (clock),
               .reset      (reset),
               .ctl        (lane_ctl[g]),
               .hold_ticks (hold_ff),
               .stat       (lane_stat[g])
            );

            assign pending[g]     = lane_stat[g].pending;
            assign levels_next[g] = lane_stat[g].pressed_next;
         end else begin : g_idle
            assign levels_next[g] = 1'b0;
         end
      end
   endgenerate

   assign arb_req.fire         = fire;
   assign arb_req.op           = op;
   assign arb_req.was_locked   = req_ch.was_locked;
   assign arb_req.time_reached = (req_ch.now_time >= req_ch.unlock_time);

   kded_event_arb u_arb (
      .clock      (clock),
      .reset      (reset),
      .req        (arb_req),
      .pending    (pending),
      .grant      (grant),
      .event_code (event_code)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         rsp_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_event_ff  <= event_code;
         rsp_levels_ff <= levels_next;
      end
   end

   assign rsp_ch.valid            = rsp_valid_ff;
   assign rsp_ch.event_code       = rsp_event_ff;
   assign rsp_ch.debounced_levels = rsp_levels_ff;

endmodule
